[design/sdpq_pkg.sv]
// ----------------------------------------------------------------------------
// sdpq_pkg: shared types and codes for the sorted double-ended priority queue
// Holds the channel payload structs, the cell control struct, the operation
// codes and the status codes.
// ----------------------------------------------------------------------------
package sdpq_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_POP_MIN = 2'd1;
  localparam logic [1:0] OP_POP_MAX = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] prio_in;
    logic [31:0]        payload_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] prio_out;
    logic [31:0]        payload_out;
    logic [4:0]         occupancy;
  } out_item_t;

  // Broadcast to every cell of the chain in the cycle of a transfer.
  typedef struct packed {
    logic               ins;
    logic               pop_min;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } cell_ctrl_t;

endpackage

[design/sdpq_cell.sv]
// ----------------------------------------------------------------------------
// sdpq_cell: one slot of the sorted chain
// Holds one key and payload, compares its key with the broadcast key, and
// takes its left or right neighbor's entry when the chain shifts.
// ----------------------------------------------------------------------------
module sdpq_cell (
  input  logic                clk,
  input  sdpq_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  logic                at_tail,
  input  logic                left_gt,
  input  logic signed [31:0]  left_key,
  input  logic [31:0]         left_payload,
  input  logic signed [31:0]  right_key,
  input  logic [31:0]         right_payload,
  output logic                gt,
  output logic signed [31:0]  key,
  output logic [31:0]         payload
);

  logic signed [31:0] key_r, key_nxt;
  logic [31:0]        pay_r, pay_nxt;

  // Strictly greater, so equal keys keep the earlier entry ahead.
  assign gt = valid && (key_r > ctrl.key);

  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctrl.ins) begin
      if (left_gt) begin
        key_nxt = left_key;
        pay_nxt = left_payload;
      end else if (gt || at_tail) begin
        key_nxt = ctrl.key;
        pay_nxt = ctrl.payload;
      end
    end else if (ctrl.pop_min) begin
      key_nxt = right_key;
      pay_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign key     = key_r;
  assign payload = pay_r;

endmodule

[design/sorted_double_ended_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_double_ended_priority_queue: sorted-chain min/max priority queue
// Keeps up to CAPACITY entries in ascending priority order in a row of cells
// and serves insert, remove-minimum and remove-maximum operations.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_item) carries one operation per
// transfer: insert, remove minimum or remove maximum. Every operation yields
// exactly one result on the output channel (out_valid, out_stall, out_item)
// with a status, the removed entry (zero when nothing is removed) and the
// occupancy after the operation.
// The result is registered at the edge that accepts the operation.
// Throughput is one operation per cycle while in_stall is low; every cell
// compares its key with the new key and moves in the same cycle as the
// transfer. The output register is refilled in the same cycle it is
// emptied.
// When the receiver stalls with a result held, in_stall rises and no new
// transfer is taken until the held result goes out.
// Reset (rst_n low, synchronous) empties the queue and drops any held
// result; cell contents are not cleared since only occupied cells are read.
// Among equal priorities, entries leave in insertion order from the head.
// ----------------------------------------------------------------------------
module sorted_double_ended_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sdpq_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sdpq_pkg::out_item_t  out_item
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  sdpq_pkg::out_item_t out_item_r, out_item_nxt;

  logic                in_xfer;
  logic                is_full, is_empty;
  sdpq_pkg::cell_ctrl_t ctrl;

  // Per-cell occupancy flags, comparison results and contents.
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_tail;
  logic [CAPACITY-1:0] cell_last;
  logic [CAPACITY-1:0] cell_gt;
  logic signed [31:0]  cell_key [CAPACITY];
  logic [31:0]         cell_pay [CAPACITY];

  logic signed [31:0]  max_key;
  logic [31:0]         max_pay;
  logic [CW+4:0]       count_ext;

  // The held result blocks new work only while the receiver stalls.
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    ctrl.ins     = in_xfer && (in_item.opcode == sdpq_pkg::OP_INSERT) && !is_full;
    ctrl.pop_min = in_xfer && (in_item.opcode == sdpq_pkg::OP_POP_MIN) && !is_empty;
    ctrl.key     = in_item.prio_in;
    ctrl.payload = in_item.payload_in;
  end

  // Cell i is occupied below the count; the cell at the count is the free
  // slot an insert lands in when no occupied key is greater.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_valid[i] = (count_r > CW'(i));
      cell_tail[i]  = (count_r == CW'(i));
      cell_last[i]  = (count_r == CW'(i + 1));
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic               l_gt;
    logic signed [31:0] l_key, r_key;
    logic [31:0]        l_pay, r_pay;

    if (g == 0) begin : g_head
      assign l_gt  = 1'b0;
      assign l_key = '0;
      assign l_pay = '0;
    end else begin : g_mid
      assign l_gt  = cell_gt[g-1];
      assign l_key = cell_key[g-1];
      assign l_pay = cell_pay[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign r_key = '0;
      assign r_pay = '0;
    end else begin : g_inner
      assign r_key = cell_key[g+1];
      assign r_pay = cell_pay[g+1];
    end

    sdpq_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .valid         (cell_valid[g]),
      .at_tail       (cell_tail[g]),
      .left_gt       (l_gt),
      .left_key      (l_key),
      .left_payload  (l_pay),
      .right_key     (r_key),
      .right_payload (r_pay),
      .gt            (cell_gt[g]),
      .key           (cell_key[g]),
      .payload       (cell_pay[g])
    );
  end

  // The tail entry is picked by an AND-OR over the one-hot last-cell flags.
  always_comb begin
    max_key = '0;
    max_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      max_key = max_key | (cell_key[i] & {32{cell_last[i]}});
      max_pay = max_pay | (cell_pay[i] & {32{cell_last[i]}});
    end
  end

  always_comb begin
    count_nxt               = count_r;
    out_item_nxt            = out_item_r;
    out_item_nxt.status     = sdpq_pkg::ST_OK;
    out_item_nxt.prio_out   = '0;
    out_item_nxt.payload_out = '0;
    if (in_xfer) begin
      case (in_item.opcode)
        sdpq_pkg::OP_INSERT: begin
          if (is_full) begin
            out_item_nxt.status = sdpq_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
        sdpq_pkg::OP_POP_MIN: begin
          if (is_empty) begin
            out_item_nxt.status = sdpq_pkg::ST_EMPTY;
          end else begin
            out_item_nxt.prio_out    = cell_key[0];
            out_item_nxt.payload_out = cell_pay[0];
            count_nxt                = count_r - CW'(1);
          end
        end
        sdpq_pkg::OP_POP_MAX: begin
          if (is_empty) begin
            out_item_nxt.status = sdpq_pkg::ST_EMPTY;
          end else begin
            out_item_nxt.prio_out    = max_key;
            out_item_nxt.payload_out = max_pay;
            count_nxt                = count_r - CW'(1);
          end
        end
        default: begin
          // Unused code: no change, plain OK result.
        end
      endcase
    end
    count_ext              = {5'd0, count_nxt};
    out_item_nxt.occupancy = count_ext[4:0];
    if (!in_xfer) begin
      out_item_nxt = out_item_r;
    end
  end

  always_comb begin
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
